### hdl/vdt_pkg.sv
// Shared types and sizing constants for the vertex deduplication table.
// Used by vdt_ctrl, vdt_datapath and vertex_dedup_table; depends on nothing.
package vdt_pkg;

    // Table depth and derived index widths.
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    // Field widths of one input item and one result item.
    localparam int GROUP_W = 16;
    localparam int REF_W   = 20;
    localparam int VIDX_W  = 8;

    typedef logic [IDX_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [VIDX_W-1:0] vidx_t;

    // One stored key: all four fields must match for a hit.
    typedef struct packed {
        logic [GROUP_W-1:0] smooth_group;
        logic [REF_W-1:0]   position_ref;
        logic [REF_W-1:0]   texture_ref;
        logic [REF_W-1:0]   normal_ref;
    } key_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;
        logic issue_read;
        logic finish_hit;
        logic finish_miss;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } status_t;

endpackage

### hdl/vertex_dedup_table.sv
// Top level of the vertex deduplication table.
// Depends on vdt_pkg, vdt_ctrl and vdt_datapath.
//
//   Channel   Handshake            Payload
//   input     s_valid / s_ready    s_smooth_group, s_position_ref, s_texture_ref, s_normal_ref
//   result    m_valid / m_ready    m_vertex_index, m_was_added, m_table_full
//
// An item scans the stored keys one per cycle through the key store's read port.
// A hit retires once the registered read of its entry compares equal; a miss retires
// once every stored entry has compared unequal, or straight after acceptance when the
// table is empty, and the controller returns to idle before the next item is taken.
// Reset is synchronous, active low, and empties the table.
// A result waits in the output register while the next item is taken and scanned;
// that scan stalls on completion until the waiting result is taken.
module vertex_dedup_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vdt_pkg::GROUP_W-1:0] s_smooth_group,
    input  logic [vdt_pkg::REF_W-1:0]   s_position_ref,
    input  logic [vdt_pkg::REF_W-1:0]   s_texture_ref,
    input  logic [vdt_pkg::REF_W-1:0]   s_normal_ref,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vdt_pkg::VIDX_W-1:0]  m_vertex_index,
    output logic                        m_was_added,
    output logic                        m_table_full
);

    vdt_pkg::cmd_t    cmd;
    vdt_pkg::status_t sts;

    // Sequencer.
    vdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Key store, scan and output register.
    vdt_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_smooth_group (s_smooth_group),
        .s_position_ref (s_position_ref),
        .s_texture_ref  (s_texture_ref),
        .s_normal_ref   (s_normal_ref),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_vertex_index (m_vertex_index),
        .m_was_added    (m_was_added),
        .m_table_full   (m_table_full)
    );

endmodule

### hdl/vdt_ctrl.sv
// Controller state machine for the vertex deduplication table.
// Depends on vdt_pkg; drives vdt_datapath through cmd_t and reads status_t.
module vdt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  vdt_pkg::status_t sts,
    output vdt_pkg::cmd_t    cmd
);

    vdt_pkg::state_t state_reg;
    vdt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == vdt_pkg::ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            vdt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    state_next   = vdt_pkg::ST_SCAN;
                end
            end
            vdt_pkg::ST_SCAN: begin
                if (sts.hit) begin
                    // Matching entry found; retire once the output slot is free.
                    if (sts.out_free) begin
                        cmd.finish_hit = 1'b1;
                        state_next     = vdt_pkg::ST_IDLE;
                    end
                end else if (sts.exhausted) begin
                    // Every stored entry compared without a match.
                    if (sts.out_free) begin
                        cmd.finish_miss = 1'b1;
                        state_next      = vdt_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.issue_read = 1'b1;
                end
            end
            default: begin
                state_next = vdt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/vdt_datapath.sv
// Datapath of the vertex deduplication table: key store memory, scan pointer,
// entry count and output register. Depends on vdt_pkg; commanded by vdt_ctrl.
module vdt_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  vdt_pkg::cmd_t               cmd,
    output vdt_pkg::status_t            sts,
    input  logic [vdt_pkg::GROUP_W-1:0] s_smooth_group,
    input  logic [vdt_pkg::REF_W-1:0]   s_position_ref,
    input  logic [vdt_pkg::REF_W-1:0]   s_texture_ref,
    input  logic [vdt_pkg::REF_W-1:0]   s_normal_ref,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vdt_pkg::VIDX_W-1:0]  m_vertex_index,
    output logic                        m_was_added,
    output logic                        m_table_full
);

    vdt_pkg::key_t   mem [vdt_pkg::ENTRIES];

    vdt_pkg::key_t   key_reg;
    vdt_pkg::key_t   rd_data_reg;
    vdt_pkg::count_t scan_idx_reg;
    vdt_pkg::count_t rd_idx_reg;
    logic            rd_valid_reg;
    vdt_pkg::count_t count_reg;
    vdt_pkg::count_t count_next;

    logic            m_valid_reg;
    logic            m_valid_next;
    vdt_pkg::vidx_t  vertex_index_reg;
    logic            was_added_reg;
    logic            table_full_reg;

    logic            full;
    logic            insert;
    logic            read_en;

    assign full    = (count_reg == vdt_pkg::count_t'(vdt_pkg::ENTRIES));
    assign insert  = cmd.finish_miss && !full;
    assign read_en = cmd.issue_read && (scan_idx_reg < count_reg);

    // Status toward the controller.
    assign sts.hit       = rd_valid_reg && (rd_data_reg == key_reg);
    assign sts.exhausted = !rd_valid_reg && (scan_idx_reg == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Key capture on the accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg.smooth_group <= s_smooth_group;
            key_reg.position_ref <= s_position_ref;
            key_reg.texture_ref  <= s_texture_ref;
            key_reg.normal_ref   <= s_normal_ref;
        end
    end

    // Key store: one write port for appends, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (insert) begin
            mem[count_reg[vdt_pkg::IDX_W-1:0]] <= key_reg;
        end
        if (read_en) begin
            rd_data_reg <= mem[scan_idx_reg[vdt_pkg::IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg;
        end
    end

    // Scan pointer and read-data valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else if (cmd.load_key) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else if (cmd.issue_read) begin
            rd_valid_reg <= read_en;
            if (read_en) begin
                scan_idx_reg <= scan_idx_reg + vdt_pkg::count_t'(1);
            end
        end
    end

    // Entry count grows by one on each append.
    always_comb begin
        count_next = count_reg;
        if (insert) begin
            count_next = count_reg + vdt_pkg::count_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Output register; it holds a result until the item is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish_hit || cmd.finish_miss) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish_hit) begin
            vertex_index_reg <= vdt_pkg::vidx_t'(rd_idx_reg);
            was_added_reg    <= 1'b0;
            table_full_reg   <= 1'b0;
        end else if (cmd.finish_miss) begin
            vertex_index_reg <= full ? '0 : vdt_pkg::vidx_t'(count_reg);
            was_added_reg    <= !full;
            table_full_reg   <= full;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_vertex_index = vertex_index_reg;
    assign m_was_added    = was_added_reg;
    assign m_table_full   = table_full_reg;

`ifndef SYNTHESIS
    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= vdt_pkg::count_t'(vdt_pkg::ENTRIES))
        else $error("entry count exceeds table depth");

    // Only written entries are ever compared.
    a_read_written: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (rd_idx_reg < count_reg))
        else $error("compared an entry that was never written");

    // A result is only loaded into a free output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish_hit || cmd.finish_miss) |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending item");

    // An append advances the count by exactly one.
    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        insert |=> (count_reg == $past(count_reg) + vdt_pkg::count_t'(1)))
        else $error("append did not advance entry count");
`endif

endmodule
